[hw/rtl/dual_polyblep_saw_oscillator_top_macros.svh]
// assertion macros for the dual polyblep saw oscillator
`ifndef DUAL_POLYBLEP_SAW_OSCILLATOR_TOP_MACROS_SVH
`define DUAL_POLYBLEP_SAW_OSCILLATOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define DPBS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dpbs assertion failed");
// next-cycle implication
`define DPBS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dpbs assertion failed");
// implication after a fixed number of cycles
`define DPBS_ASSERT_DLY(label, clk, rstn, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##n (cons)) \
        else $error("dpbs assertion failed");
`else
`define DPBS_ASSERT_IMP(label, clk, rstn, ante, cons)
`define DPBS_ASSERT_NXT(label, clk, rstn, ante, cons)
`define DPBS_ASSERT_DLY(label, clk, rstn, ante, n, cons)
`endif
`endif

[hw/rtl/dpbs_pkg.sv]
`timescale 1ns / 1ps
package dpbs_pkg;

    localparam int DATA_W      = 32;
    localparam int HALF_W      = 16;
    localparam int OUT_W       = 29;
    localparam int DIV_STEPS   = 32;
    localparam int CNT_W       = $clog2(DIV_STEPS);
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 32;

    localparam logic [HALF_W-1:0] FRAC_MAX   = 16'hFFFF;
    localparam logic [OUT_W-1:0]  OUT_OFFSET = 29'h1000_0000;
    localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(DIV_STEPS - 1);

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV,
        ST_DIV,
        ST_SQR,
        ST_FIX,
        ST_HAND
    } state_t;

    // per-step strobes shared by both lanes
    typedef struct packed {
        logic load;
        logic advance;
        logic divide;
        logic square;
        logic fix;
    } lane_ctrl_t;

endpackage

[hw/rtl/dpbs_lane.sv]
`timescale 1ns / 1ps
module dpbs_lane (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  dpbs_pkg::lane_ctrl_t           ctrl,
    input  logic                           op,
    input  logic signed [dpbs_pkg::DATA_W-1:0] value,
    output logic [dpbs_pkg::DATA_W-1:0]    sample
);
    import dpbs_pkg::*;

    logic [DATA_W-1:0] inc_reg;
    logic [DATA_W-1:0] phase_reg;
    logic [DATA_W-1:0] prev_reg;
    logic [DATA_W-1:0] sample_reg;
    logic [DATA_W-1:0] divisor_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] sq_lo_reg;
    logic [DATA_W-1:0] sq_hi_reg;
    logic              wrap_reg;

    logic [DATA_W-1:0] adv_sum;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   trial_diff;
    logic [HALF_W-1:0] frac;
    logic [HALF_W-1:0] frac_inv;

    // phase advance
    assign adv_sum = phase_reg + inc_reg;

    // one restoring division step: a borrow means the divisor does not fit
    assign trial      = {rem_reg, quo_reg[DATA_W-1]};
    assign trial_diff = trial - {1'b0, divisor_reg};

    // saturate the quotient; a zero divisor leaves all ones, so it saturates too
    assign frac     = (quo_reg[DATA_W-1:HALF_W] != '0) ? FRAC_MAX : quo_reg[HALF_W-1:0];
    assign frac_inv = ~frac;

    // oscillator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inc_reg   <= '0;
            phase_reg <= '0;
            prev_reg  <= '0;
        end else begin
            if (ctrl.load) begin
                inc_reg <= op ? $unsigned(value) : inc_reg + $unsigned(value);
            end
            if (ctrl.advance) begin
                phase_reg <= adv_sum;
            end
            if (ctrl.fix) begin
                prev_reg <= wrap_reg ? phase_reg + {1'b0, sq_hi_reg[DATA_W-1:1]} : phase_reg;
            end
        end
    end

    // edge time divider and squarers
    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            wrap_reg    <= (adv_sum < inc_reg);
            divisor_reg <= {{HALF_W{inc_reg[DATA_W-1]}}, inc_reg[DATA_W-1:HALF_W]};
            rem_reg     <= '0;
            quo_reg     <= adv_sum;
        end else if (ctrl.divide) begin
            if (trial_diff[DATA_W]) begin
                rem_reg <= trial[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end else begin
                rem_reg <= trial_diff[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end
        end
        if (ctrl.square) begin
            sq_lo_reg <= {{HALF_W{1'b0}}, frac} * {{HALF_W{1'b0}}, frac};
            sq_hi_reg <= {{HALF_W{1'b0}}, frac_inv} * {{HALF_W{1'b0}}, frac_inv};
        end
        if (ctrl.fix) begin
            sample_reg <= wrap_reg ? prev_reg - {1'b0, sq_lo_reg[DATA_W-1:1]} : prev_reg;
        end
    end

    assign sample = sample_reg;

endmodule

[hw/rtl/dpbs_merge.sv]
`timescale 1ns / 1ps
module dpbs_merge (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             load,
    input  logic                             pulse,
    input  logic [dpbs_pkg::DATA_W-1:0]      sample_one,
    input  logic [dpbs_pkg::DATA_W-1:0]      sample_two,
    output logic                             ready,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // sample_out [28:0], zeros [31:29]
    output logic [dpbs_pkg::M_TDATA_W-1:0]   m_tdata
);
    import dpbs_pkg::*;

    logic [DATA_W-1:0] two_sel;
    logic [OUT_W-1:0]  mix;
    logic [OUT_W-1:0]  out_reg;
    logic              valid_reg;

    // pulse mode inverts the second oscillator, then both are scaled and summed
    assign two_sel = pulse ? ~sample_two : sample_two;
    assign mix     = {1'b0, sample_one[DATA_W-1:4]} + {1'b0, two_sel[DATA_W-1:4]} - OUT_OFFSET;

    assign ready = !valid_reg || m_tready;

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= mix;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_TDATA_W-OUT_W){1'b0}}, out_reg};

endmodule

[hw/rtl/dual_polyblep_saw_oscillator_top.sv]
// Dual polyBLEP sawtooth oscillator: each accepted word updates both phase increments
// (tuser selects load or glide add), advances both 32-bit phases and returns one mixed
// sample. Per item it updates the increments, advances the phases, runs the bit-serial
// restoring divider that finds the edge time in each lane, drives the squarers, applies
// the corrections and hands the pair to the output register, waiting there while that
// register holds a sample that is not being read. The result waits in that register, so a
// new word is taken while the previous sample is still unread.
`timescale 1ns / 1ps
`include "dual_polyblep_saw_oscillator_top_macros.svh"
module dual_polyblep_saw_oscillator_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // value_one [31:0], value_two [63:32], pulse_mode [64], zeros [71:65]
    input  logic [dpbs_pkg::S_TDATA_W-1:0]   s_tdata,
    // op [0]
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // sample_out [28:0], zeros [31:29]
    output logic [dpbs_pkg::M_TDATA_W-1:0]   m_tdata
);
    import dpbs_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic              pulse_reg;
    lane_ctrl_t        lane_ctrl;
    logic              merge_load;
    logic              merge_ready;
    logic              in_ready;
    logic [DATA_W-1:0] sample_one;
    logic [DATA_W-1:0] sample_two;

    // state and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DIV) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else begin
                cnt_reg <= '0;
            end
        end
    end

    // pulse mode travels with the item to the mixer
    always_ff @(posedge aclk) begin
        if (s_tvalid && in_ready) begin
            pulse_reg <= s_tdata[2*DATA_W];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_ADV;
            end
            ST_ADV:  state_next = ST_DIV;
            ST_DIV: begin
                if (cnt_reg == CNT_LAST) state_next = ST_SQR;
            end
            ST_SQR:  state_next = ST_FIX;
            ST_FIX:  state_next = ST_HAND;
            ST_HAND: begin
                if (merge_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // step strobes
    always_comb begin
        lane_ctrl  = '0;
        in_ready   = 1'b0;
        merge_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready       = 1'b1;
                lane_ctrl.load = s_tvalid;
            end
            ST_ADV:  lane_ctrl.advance = 1'b1;
            ST_DIV:  lane_ctrl.divide  = 1'b1;
            ST_SQR:  lane_ctrl.square  = 1'b1;
            ST_FIX:  lane_ctrl.fix     = 1'b1;
            ST_HAND: merge_load        = merge_ready;
            default: lane_ctrl = '0;
        endcase
    end

    assign s_tready = in_ready;

    // oscillator lanes
    dpbs_lane u_lane_one (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (lane_ctrl),
        .op      (s_tuser[0]),
        .value   (s_tdata[DATA_W-1:0]),
        .sample  (sample_one)
    );

    dpbs_lane u_lane_two (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (lane_ctrl),
        .op      (s_tuser[0]),
        .value   (s_tdata[2*DATA_W-1:DATA_W]),
        .sample  (sample_two)
    );

    // mixer and output register
    dpbs_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (merge_load),
        .pulse      (pulse_reg),
        .sample_one (sample_one),
        .sample_two (sample_two),
        .ready      (merge_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // at most one lane step at a time
    `DPBS_ASSERT_IMP(a_ctrl_onehot, aclk, aresetn, 1'b1, $onehot0({lane_ctrl.load, lane_ctrl.advance, lane_ctrl.divide, lane_ctrl.square, lane_ctrl.fix}))
    // an accepted word reaches the hand-over after a fixed latency
    `DPBS_ASSERT_DLY(a_latency, aclk, aresetn, s_tvalid && s_tready, 36, state_reg == ST_HAND)
    // the mixer only loads when its output register is free
    `DPBS_ASSERT_IMP(a_load_free, aclk, aresetn, merge_load, !m_tvalid || m_tready)
    // a loaded result is shown on the next cycle
    `DPBS_ASSERT_NXT(a_load_shown, aclk, aresetn, merge_load, m_tvalid && !s_tready == 1'b0)

endmodule
